/* hdl/owse_pkg.sv */
package owse_pkg;

   localparam int ROM_BYTES = 8;
   localparam int ROM_BITS  = ROM_BYTES * 8;
   localparam int POS_W     = $clog2(ROM_BITS + 2);
   localparam int IDX_W     = $clog2(ROM_BITS);
   localparam int BYTE_W    = $clog2(ROM_BYTES);

   localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(ROM_BITS);
   localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);
   localparam logic [7:0]       CRC_POLY     = 8'h8C;

   typedef enum logic [2:0] {
      CMD_FIRST    = 3'd0,
      CMD_NEXT     = 3'd1,
      CMD_VERIFY   = 3'd2,
      CMD_TARGET   = 3'd3,
      CMD_SKIP     = 3'd4,
      CMD_PRESENCE = 3'd5,
      CMD_BIT_PAIR = 3'd6
   } cmd_type;

   // ACT_SEARCH_BYTE asks the bus side to send the search ROM byte (F0)
   typedef enum logic [1:0] {
      ACT_NONE        = 2'd0,
      ACT_RESET       = 2'd1,
      ACT_SEARCH_BYTE = 2'd2,
      ACT_WRITE_BIT   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESENCE = 2'd1,
      PH_BITS     = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] family_byte;
      logic       presence_seen;
      logic       id_bit;
      logic       complement_bit;
   } req_type;

   typedef struct packed {
      logic [1:0]          action;
      logic                direction_bit;
      logic                search_done;
      logic                device_found;
      logic                device_verified;
      logic [ROM_BITS-1:0] rom_code;
      logic                sequence_error;
   } rsp_type;

   // backup_flags: [6:0] last discrepancy, [13:7] last family discrepancy, [14] last device
   typedef struct packed {
      phase_type             phase;
      logic                  verify_active;
      logic [ROM_BITS-1:0]   rom;
      logic [POS_W-1:0]      last_disc;
      logic [POS_W-1:0]      last_fam_disc;
      logic                  last_device;
      logic [POS_W-1:0]      bit_pos;
      logic [POS_W-1:0]      zero_pos;
      logic [7:0]            crc;
      logic [ROM_BITS-1:0]   backup_rom;
      logic [2*POS_W:0]      backup_flags;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_IDLE,
      verify_active: 1'b0,
      rom:           '0,
      last_disc:     '0,
      last_fam_disc: '0,
      last_device:   1'b0,
      bit_pos:       POS_FIRST,
      zero_pos:      '0,
      crc:           '0,
      backup_rom:    '0,
      backup_flags:  '0
   };

   // Dallas CRC-8, reflected, LSB first
   function automatic logic [7:0] crc_byte(input logic [7:0] crc_cur, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc_cur;
      d = data;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ d[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

/* hdl/one_wire_rom_search_engine_unit.sv */
// 1-Wire ROM search engine. Each request transaction carries one bus event or command
// (start first, start next, verify, target family, skip family, presence result, bit pair)
// and yields exactly one response transaction: the next bus action, the direction bit
// to write, pass-done and found/verified flags, the current 64-bit ROM code and a
// sequence error flag for a command that does not fit the current phase or is unused. One
// request is taken per clock while the response side is not stalled; the request register
// feeds the combinational search step, and the response register loads the step result
// when it is empty or its response is being taken.
// Back-pressure on rsp_ready holds the response and, once the request register is also
// full, drops req_ready.
module one_wire_rom_search_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_family_byte,
   input  logic        req_presence_seen,
   input  logic        req_id_bit,
   input  logic        req_complement_bit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic        rsp_direction_bit,
   output logic        rsp_search_done,
   output logic        rsp_device_found,
   output logic        rsp_device_verified,
   output logic [63:0] rsp_rom_code,
   output logic        rsp_sequence_error
);
   import owse_pkg::*;

   req_type   req_ff;
   req_type   req_in;
   logic      req_valid_ff;
   logic      req_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   state_type state_ff;
   state_type state_in;
   state_type step_state;
   rsp_type   step_rsp;
   logic      advance;
   logic      take_req;

   owse_step u_step (
      .cur (state_ff),
      .req (req_ff),
      .nxt (step_state),
      .rsp (step_rsp)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      req_in = req_ff;
      if (take_req) begin
         req_in.command        = req_command;
         req_in.family_byte    = req_family_byte;
         req_in.presence_seen  = req_presence_seen;
         req_in.id_bit         = req_id_bit;
         req_in.complement_bit = req_complement_bit;
      end
      req_valid_in = take_req || (req_valid_ff && !advance);
      state_in     = advance ? step_state : state_ff;
      rsp_in       = advance ? step_rsp : rsp_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = rsp_ff.action;
   assign rsp_direction_bit   = rsp_ff.direction_bit;
   assign rsp_search_done     = rsp_ff.search_done;
   assign rsp_device_found    = rsp_ff.device_found;
   assign rsp_device_verified = rsp_ff.device_verified;
   assign rsp_rom_code        = rsp_ff.rom_code;
   assign rsp_sequence_error  = rsp_ff.sequence_error;

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && step_rsp.search_done |=> state_ff.phase == PH_IDLE && !state_ff.verify_active)
      else $error("finished pass did not return to idle");

   a_found_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.device_found |-> rsp_ff.search_done)
      else $error("device_found without search_done");

   a_verified_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.device_verified |-> rsp_ff.device_found)
      else $error("device_verified without device_found");

   a_error_is_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.sequence_error |->
         rsp_ff.action == ACT_NONE && !rsp_ff.search_done && !rsp_ff.direction_bit)
      else $error("ignored command produced an action");

   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_BITS |-> state_ff.bit_pos >= POS_FIRST && state_ff.bit_pos <= POS_LAST)
      else $error("bit position out of range while reading bit pairs");

endmodule

/* hdl/owse_step.sv */
module owse_step (
   input  owse_pkg::state_type cur,
   input  owse_pkg::req_type   req,
   output owse_pkg::state_type nxt,
   output owse_pkg::rsp_type   rsp
);
   import owse_pkg::*;

   always_comb begin
      cmd_type             cmd;
      logic                err;
      logic                do_finish;
      logic                fin_ok;
      logic                ok;
      logic                dir;
      logic [POS_W-1:0]    pos;
      logic [IDX_W-1:0]    idx;
      logic [BYTE_W-1:0]   byte_sel;

      cmd       = cmd_type'(req.command);
      nxt       = cur;
      rsp       = '0;
      do_finish = 1'b0;
      fin_ok    = 1'b0;
      ok        = 1'b0;
      dir       = 1'b0;
      pos       = (cur.bit_pos == '0 || cur.bit_pos > POS_LAST) ? POS_FIRST : cur.bit_pos;
      idx       = IDX_W'(pos - POS_FIRST);
      byte_sel  = idx[IDX_W-1:3];

      err = 1'b1;
      unique case (cmd) inside
         CMD_FIRST, CMD_NEXT, CMD_VERIFY, CMD_TARGET, CMD_SKIP: err = (cur.phase != PH_IDLE);
         CMD_PRESENCE: err = (cur.phase != PH_PRESENCE);
         CMD_BIT_PAIR: err = (cur.phase != PH_BITS);
         default:      err = 1'b1;
      endcase

      if (!err) begin
         unique case (cmd) inside
            CMD_FIRST, CMD_NEXT, CMD_VERIFY: begin
               if (cmd == CMD_FIRST) begin
                  nxt.last_disc     = '0;
                  nxt.last_fam_disc = '0;
                  nxt.last_device   = 1'b0;
               end
               if (cmd == CMD_VERIFY) begin
                  nxt.backup_rom    = cur.rom;
                  nxt.backup_flags  = {cur.last_device, cur.last_fam_disc, cur.last_disc};
                  nxt.last_disc     = POS_LAST;
                  nxt.last_device   = 1'b0;
                  nxt.verify_active = 1'b1;
               end
               nxt.bit_pos  = POS_FIRST;
               nxt.zero_pos = '0;
               nxt.crc      = '0;
               if (nxt.last_device) begin
                  do_finish = 1'b1;
               end else begin
                  rsp.action = ACT_RESET;
                  nxt.phase  = PH_PRESENCE;
               end
            end
            CMD_TARGET: begin
               nxt.rom           = ROM_BITS'(req.family_byte);
               nxt.last_disc     = POS_LAST;
               nxt.last_fam_disc = '0;
               nxt.last_device   = 1'b0;
            end
            CMD_SKIP: begin
               nxt.last_disc     = cur.last_fam_disc;
               nxt.last_fam_disc = '0;
               if (cur.last_fam_disc == '0) begin
                  nxt.last_device = 1'b1;
               end
            end
            CMD_PRESENCE: begin
               if (req.presence_seen) begin
                  rsp.action = ACT_SEARCH_BYTE;
                  nxt.phase  = PH_BITS;
               end else begin
                  do_finish = 1'b1;
               end
            end
            CMD_BIT_PAIR: begin
               if (req.id_bit && req.complement_bit) begin
                  // nobody on the bus answered this slot
                  do_finish = 1'b1;
               end else begin
                  if (req.id_bit != req.complement_bit) begin
                     dir = req.id_bit;
                  end else begin
                     // discrepancy: follow previous path, take 1 at the last branch point
                     if (pos < cur.last_disc) begin
                        dir = cur.rom[idx];
                     end else begin
                        dir = (pos == cur.last_disc);
                     end
                     if (!dir) begin
                        nxt.zero_pos = pos;
                        if (pos < FAMILY_LIMIT) begin
                           nxt.last_fam_disc = pos;
                        end
                     end
                  end
                  nxt.rom[idx]      = dir;
                  rsp.action        = ACT_WRITE_BIT;
                  rsp.direction_bit = dir;
                  if (pos[2:0] == 3'b000) begin
                     nxt.crc = crc_byte(cur.crc, nxt.rom[{byte_sel, 3'b000} +: 8]);
                  end
                  nxt.bit_pos = pos + POS_FIRST;
                  if (pos == POS_LAST) begin
                     fin_ok = (nxt.crc == 8'h00);
                     if (fin_ok) begin
                        nxt.last_disc = nxt.zero_pos;
                        if (nxt.zero_pos == '0) begin
                           nxt.last_device = 1'b1;
                        end
                     end
                     do_finish = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (do_finish) begin
         ok = fin_ok && (nxt.rom[7:0] != 8'h00);
         if (!ok) begin
            nxt.last_disc     = '0;
            nxt.last_fam_disc = '0;
            nxt.last_device   = 1'b0;
         end
         rsp.search_done  = 1'b1;
         rsp.device_found = ok;
         if (nxt.verify_active) begin
            rsp.device_verified = ok && (nxt.rom == nxt.backup_rom);
            nxt.rom             = nxt.backup_rom;
            nxt.last_disc       = nxt.backup_flags[POS_W-1:0];
            nxt.last_fam_disc   = nxt.backup_flags[2*POS_W-1:POS_W];
            nxt.last_device     = nxt.backup_flags[2*POS_W];
         end
         nxt.verify_active = 1'b0;
         nxt.phase         = PH_IDLE;
      end

      rsp.rom_code       = nxt.rom;
      rsp.sequence_error = err;
   end

endmodule

/* tb/one_wire_rom_search_engine_unit_test.sv */
module one_wire_rom_search_engine_unit_test;
   import owse_pkg::*;

   localparam logic [2:0] CMD_UNUSED   = 3'd7;
   localparam int         RANDOM_ITEMS = 1600;

   typedef enum {FLOW_OPEN, FLOW_LIGHT, FLOW_PATTERN, FLOW_HEAVY} flow_mode_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [7:0]  fam;
      logic        pres;
      logic        idb;
      logic        cmpb;
      bit          typed;
      action_type  act;
      logic        done;
      logic        found;
      logic [63:0] rom;
      logic        err;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = 3'd0;
   logic [7:0]  req_family_byte = 8'h00;
   logic        req_presence_seen = 1'b0;
   logic        req_id_bit = 1'b0;
   logic        req_complement_bit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_action;
   logic        rsp_direction_bit;
   logic        rsp_search_done;
   logic        rsp_device_found;
   logic        rsp_device_verified;
   logic [63:0] rsp_rom_code;
   logic        rsp_sequence_error;

   one_wire_rom_search_engine_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_family_byte     (req_family_byte),
      .req_presence_seen   (req_presence_seen),
      .req_id_bit          (req_id_bit),
      .req_complement_bit  (req_complement_bit),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_action          (rsp_action),
      .rsp_direction_bit   (rsp_direction_bit),
      .rsp_search_done     (rsp_search_done),
      .rsp_device_found    (rsp_device_found),
      .rsp_device_verified (rsp_device_verified),
      .rsp_rom_code        (rsp_rom_code),
      .rsp_sequence_error  (rsp_sequence_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // search engine shadow state
   logic [63:0] pr_rom;
   logic [63:0] pr_saved_rom;
   logic [14:0] pr_saved_flags;
   logic [6:0]  pr_last_disc;
   logic [6:0]  pr_last_fam;
   logic [6:0]  pr_pos;
   logic [6:0]  pr_zero_pos;
   logic        pr_last_dev;
   logic        pr_verify;
   logic [7:0]  pr_crc;
   phase_type   pr_phase;

   // simulated devices on the bus
   logic [63:0] bus_rom [4];
   bit          bus_live [4];
   int          bus_count = 0;

   rsp_type       expected_q[$];
   rsp_type       due;
   bit            any_failure = 1'b0;
   int            items_sent = 0;
   int            burst_left = 0;
   flow_mode_type stall_mode = FLOW_OPEN;
   int            stall_left = 0;
   logic [15:0]   stall_mask = 16'hFFFF;

   function automatic logic [7:0] dallas_crc8(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      r = acc ^ data;
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void clear_history();
      pr_last_disc = '0;
      pr_last_fam  = '0;
      pr_last_dev  = 1'b0;
   endfunction

   function automatic void end_pass(input logic ok, inout rsp_type r);
      logic good;
      good = ok && (pr_rom[7:0] != 8'h00);
      if (!good) clear_history();
      r.search_done  = 1'b1;
      r.device_found = good;
      if (pr_verify) begin
         r.device_verified = good && (pr_rom == pr_saved_rom);
         pr_rom = pr_saved_rom;
         {pr_last_dev, pr_last_fam, pr_last_disc} = pr_saved_flags;
      end
      pr_verify = 1'b0;
      pr_phase  = PH_IDLE;
   endfunction

   function automatic void start_pass(inout rsp_type r);
      pr_pos      = POS_FIRST;
      pr_zero_pos = '0;
      pr_crc      = 8'h00;
      if (pr_last_dev) begin
         end_pass(1'b0, r);
      end else begin
         r.action = ACT_RESET;
         pr_phase = PH_PRESENCE;
      end
   endfunction

   function automatic void take_pair(input logic idb, input logic cmpb, inout rsp_type r);
      int   pos;
      int   idx;
      logic d;
      pos = pr_pos;
      if (pos < 1 || pos > ROM_BITS) pos = 1;
      idx = pos - 1;
      if (idb && cmpb) begin
         end_pass(1'b0, r);
         return;
      end
      if (idb != cmpb) begin
         d = idb;
      end else begin
         if (pos < pr_last_disc) d = pr_rom[idx];
         else d = (pos == pr_last_disc);
         if (!d) begin
            pr_zero_pos = 7'(pos);
            if (pos < FAMILY_LIMIT) pr_last_fam = 7'(pos);
         end
      end
      pr_rom[idx]     = d;
      r.action        = ACT_WRITE_BIT;
      r.direction_bit = d;
      if (pos % 8 == 0) pr_crc = dallas_crc8(pr_crc, pr_rom[(idx / 8) * 8 +: 8]);
      pos++;
      pr_pos = 7'(pos);
      if (pos > ROM_BITS) begin
         if (pr_crc == 8'h00) begin
            pr_last_disc = pr_zero_pos;
            if (pr_last_disc == '0) pr_last_dev = 1'b1;
         end
         end_pass(pr_crc == 8'h00, r);
      end
   endfunction

   function automatic rsp_type search_step(input req_type item);
      rsp_type    r;
      logic [2:0] cmd;
      bit         bad;
      r   = '0;
      cmd = item.command;
      bad = (cmd == CMD_UNUSED)
         || (cmd <= CMD_SKIP && pr_phase != PH_IDLE)
         || (cmd == CMD_PRESENCE && pr_phase != PH_PRESENCE)
         || (cmd == CMD_BIT_PAIR && pr_phase != PH_BITS);
      if (!bad) begin
         case (cmd)
            CMD_FIRST: begin
               clear_history();
               start_pass(r);
            end
            CMD_NEXT: start_pass(r);
            CMD_VERIFY: begin
               pr_saved_rom   = pr_rom;
               pr_saved_flags = {pr_last_dev, pr_last_fam, pr_last_disc};
               pr_last_disc   = 7'(ROM_BITS);
               pr_last_dev    = 1'b0;
               pr_verify      = 1'b1;
               start_pass(r);
            end
            CMD_TARGET: begin
               pr_rom       = {56'h0, item.family_byte};
               pr_last_disc = 7'(ROM_BITS);
               pr_last_fam  = '0;
               pr_last_dev  = 1'b0;
            end
            CMD_SKIP: begin
               pr_last_disc = pr_last_fam;
               pr_last_fam  = '0;
               if (pr_last_disc == '0) pr_last_dev = 1'b1;
            end
            CMD_PRESENCE: begin
               if (item.presence_seen) begin
                  r.action = ACT_SEARCH_BYTE;
                  pr_phase = PH_BITS;
               end else begin
                  end_pass(1'b0, r);
               end
            end
            default: take_pair(item.id_bit, item.complement_bit, r);
         endcase
      end
      r.rom_code       = pr_rom;
      r.sequence_error = bad;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.command        = 3'($urandom_range(0, 7));
      r.family_byte    = 8'($urandom_range(0, 255));
      r.presence_seen  = 1'($urandom_range(0, 1));
      r.id_bit         = 1'($urandom_range(0, 1));
      r.complement_bit = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // predicts, tracks which simulated devices still follow the search, then drives
   task automatic issue(input req_type item, input bit typed, input rsp_type typed_want);
      rsp_type got;
      int      idx;
      int      gap;
      idx = (pr_pos >= POS_FIRST && pr_pos <= POS_LAST) ? int'(pr_pos) - 1 : 0;
      got = search_step(item);
      for (int k = 0; k < 4; k++) begin
         if (got.action == ACT_SEARCH_BYTE) bus_live[k] = 1'b1;
         else if (got.action == ACT_WRITE_BIT && bus_rom[k][idx] != got.direction_bit)
            bus_live[k] = 1'b0;
      end
      expected_q.push_back(typed ? typed_want : got);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid          = 1'b1;
      req_command        = item.command;
      req_family_byte    = item.family_byte;
      req_presence_seen  = item.presence_seen;
      req_id_bit         = item.id_bit;
      req_complement_bit = item.complement_bit;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic void note_mismatch(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      any_failure = 1'b1;
   endfunction

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = flow_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 120);
         stall_mask = 16'($urandom);
      end
      stall_left--;
      case (stall_mode)
         FLOW_OPEN:    rsp_ready = 1'b1;
         FLOW_LIGHT:   rsp_ready = ($urandom_range(0, 3) != 0);
         FLOW_PATTERN: rsp_ready = stall_mask[stall_left % 16];
         default:      rsp_ready = ($urandom_range(0, 2) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction, rom %h", $time, rsp_rom_code);
            any_failure = 1'b1;
         end else begin
            due = expected_q.pop_front();
            if (rsp_action !== due.action)
               note_mismatch("action", 64'(due.action), 64'(rsp_action));
            if (rsp_direction_bit !== due.direction_bit)
               note_mismatch("direction_bit", 64'(due.direction_bit),
                             64'(rsp_direction_bit));
            if (rsp_search_done !== due.search_done)
               note_mismatch("search_done", 64'(due.search_done), 64'(rsp_search_done));
            if (rsp_device_found !== due.device_found)
               note_mismatch("device_found", 64'(due.device_found), 64'(rsp_device_found));
            if (rsp_device_verified !== due.device_verified)
               note_mismatch("device_verified", 64'(due.device_verified),
                             64'(rsp_device_verified));
            if (rsp_rom_code !== due.rom_code)
               note_mismatch("rom_code", due.rom_code, rsp_rom_code);
            if (rsp_sequence_error !== due.sequence_error)
               note_mismatch("sequence_error", 64'(due.sequence_error),
                             64'(rsp_sequence_error));
         end
      end
   end

   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      stim_row_type stim_table[$];
      req_type      item;
      rsp_type      want;
      int           pick;
      int           session_left;
      logic [63:0]  base;
      logic [55:0]  body;
      logic [7:0]   crc;

      pr_rom         = '0;
      pr_saved_rom   = '0;
      pr_saved_flags = '0;
      pr_pos         = POS_FIRST;
      pr_zero_pos    = '0;
      pr_crc         = 8'h00;
      pr_verify      = 1'b0;
      pr_phase       = PH_IDLE;
      clear_history();
      for (int k = 0; k < 4; k++) begin
         bus_rom[k]  = '0;
         bus_live[k] = 1'b0;
      end

      // wrong-phase and unused commands, start after last device, no presence,
      // both bits high, discrepancy handling, skip with nothing left
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b1});
      stim_table.push_back('{CMD_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b1});
      stim_table.push_back('{CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b1});
      stim_table.push_back('{CMD_SKIP, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_NEXT, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b1, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_TARGET, 8'hFF, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'hFF, 1'b0});
      stim_table.push_back('{CMD_FIRST, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_RESET, 1'b0, 1'b0, 64'hFF, 1'b0});
      stim_table.push_back('{CMD_VERIFY, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'hFF, 1'b1});
      stim_table.push_back('{CMD_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b1, 1'b0, 64'hFF, 1'b0});
      stim_table.push_back('{CMD_TARGET, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_VERIFY, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b1});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b1,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_FIRST, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1,
                             1'b0, ACT_NONE, 1'b0, 1'b0, 64'h0, 1'b0});
      stim_table.push_back('{CMD_TARGET, 8'h5A, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h5A, 1'b0});
      stim_table.push_back('{CMD_SKIP, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h5A, 1'b0});
      stim_table.push_back('{CMD_FIRST, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_RESET, 1'b0, 1'b0, 64'h5A, 1'b0});
      stim_table.push_back('{CMD_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b0, 1'b0, 64'h5A, 1'b1});
      stim_table.push_back('{CMD_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0,
                             1'b1, ACT_NONE, 1'b1, 1'b0, 64'h5A, 1'b0});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[i]) begin
         item.command         = stim_table[i].cmd;
         item.family_byte     = stim_table[i].fam;
         item.presence_seen   = stim_table[i].pres;
         item.id_bit          = stim_table[i].idb;
         item.complement_bit  = stim_table[i].cmpb;
         want                 = '0;
         want.action          = stim_table[i].act;
         want.search_done     = stim_table[i].done;
         want.device_found    = stim_table[i].found;
         want.rom_code        = stim_table[i].rom;
         want.sequence_error  = stim_table[i].err;
         issue(item, stim_table[i].typed, want);
      end
      wait_drained();

      // sessions of search commands against a random device population
      session_left = 0;
      while (items_sent < stim_table.size() + RANDOM_ITEMS) begin
         if (session_left == 0) begin
            session_left = $urandom_range(4, 12);
            if ($urandom_range(0, 3) == 0) wait_drained();
            bus_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            base = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0) base[7:0] = 8'h28;
            for (int k = 0; k < 4; k++) begin
               body = base[55:0];
               if (k > 0) repeat ($urandom_range(1, 4)) body[$urandom_range(8, 55)] ^= 1'b1;
               case ($urandom_range(0, 19))
                  0:          body[7:0] = 8'h00;
                  1, 2, 3, 4: body[7:0] = 8'($urandom);
                  5, 6, 7:    body[7:0] = 8'h10;
                  default:    ;
               endcase
               crc = 8'h00;
               for (int b = 0; b < 7; b++) crc = dallas_crc8(crc, body[8 * b +: 8]);
               if ($urandom_range(0, 11) == 0) crc = crc ^ (8'h01 << $urandom_range(0, 7));
               bus_rom[k]  = {crc, body};
               bus_live[k] = 1'b0;
            end
         end
         session_left--;

         item = random_item();
         pick = $urandom_range(0, 99);
         if (pick < 45) item.command = CMD_NEXT;
         else if (pick < 60) item.command = CMD_FIRST;
         else if (pick < 75) item.command = CMD_VERIFY;
         else if (pick < 85) begin
            item.command = CMD_TARGET;
            if (bus_count != 0 && $urandom_range(0, 2) != 0)
               item.family_byte = bus_rom[$urandom_range(0, bus_count - 1)][7:0];
         end
         else if (pick < 95) item.command = CMD_SKIP;
         issue(item, 1'b0, '0);

         // play the bus side until the pass ends, with occasional noise
         while (pr_phase != PH_IDLE) begin
            item = random_item();
            if ($urandom_range(0, 49) != 0) begin
               if (pr_phase == PH_PRESENCE) begin
                  item.command       = CMD_PRESENCE;
                  item.presence_seen = (bus_count != 0) ^ ($urandom_range(0, 19) == 0);
               end else begin
                  item.command        = CMD_BIT_PAIR;
                  item.id_bit         = 1'b1;
                  item.complement_bit = 1'b1;
                  // wired-AND of every device still in the search
                  for (int k = 0; k < bus_count; k++) begin
                     if (bus_live[k]) begin
                        item.id_bit         &= bus_rom[k][int'(pr_pos) - 1];
                        item.complement_bit &= ~bus_rom[k][int'(pr_pos) - 1];
                     end
                  end
                  if ($urandom_range(0, 99) == 0) begin
                     item.id_bit         = 1'($urandom_range(0, 1));
                     item.complement_bit = 1'($urandom_range(0, 1));
                  end
               end
            end
            issue(item, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (!any_failure) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
